// File: design/scou_pkg.sv
// ----------------------------------------------------------------------------
// scou_pkg
// shared widths, reset values and sideband types for the segment crossing block
// ----------------------------------------------------------------------------
package scou_pkg;

    localparam int COORD_BITS      = 32;
    localparam int COORD_FRAC_BITS = 16;   // result does not depend on it
    localparam int PARAM_FRAC_BITS = 30;

    localparam int DIFF_W  = COORD_BITS + 1;       // coordinate difference
    localparam int PROD_W  = 2 * DIFF_W;           // product of two differences
    localparam int DET_W   = PROD_W + 1;           // determinant and numerators
    localparam int NUM_W   = DET_W + 1;            // numerators after sign fold
    localparam int SPLIT   = 34;                   // low slice of the determinant
    localparam int TOL_W   = 30;
    localparam int HI_W    = PARAM_FRAC_BITS + 1;
    localparam int WIN_W   = NUM_W + PARAM_FRAC_BITS + 2;
    localparam int EPSD_W  = TOL_W + DET_W;
    localparam int HID_W   = HI_W + DET_W;
    localparam int HGT_W   = 104;                  // exact height products
    localparam int REM_W   = DET_W + PARAM_FRAC_BITS + 2;
    localparam int Q_W     = PARAM_FRAC_BITS + 1;
    localparam int POS_W   = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1074);
    localparam logic [HI_W-1:0]  ONE_Q     = HI_W'(1) << PARAM_FRAC_BITS;

    localparam logic signed [1:0] TOP_A    = 2'sb01;
    localparam logic signed [1:0] TOP_B    = 2'sb11;
    localparam logic signed [1:0] TOP_NONE = 2'sb00;

    typedef struct packed {
        logic crossed;
        logic top;
        logic negout;
    } t_side;

endpackage

// File: design/scou_divider.sv
// ----------------------------------------------------------------------------
// scou_divider
// restoring divider, one quotient bit per pipeline stage, msb first
// ----------------------------------------------------------------------------
module scou_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [scou_pkg::REM_W-1:0]      i_rem,
    input  logic [scou_pkg::DET_W-1:0]      i_det,
    input  scou_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic [scou_pkg::Q_W-1:0]        o_quot,
    output scou_pkg::t_side                 o_side
);
    import scou_pkg::*;

    logic [Q_W-1:0]               r_v;
    logic [REM_W-1:0]             r_rem  [Q_W];
    logic [DET_W-1:0]             r_det  [Q_W];
    logic [Q_W-1:0]               r_quot [Q_W];
    t_side                        r_side [Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Q_W-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int BIT = Q_W - 1 - k;
        logic [REM_W-1:0] rem_in;
        logic [DET_W-1:0] det_in;
        logic [Q_W-1:0]   quot_in;
        t_side            side_in;
        logic [REM_W-1:0] t;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in  = i_rem;
            assign det_in  = i_det;
            assign quot_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign det_in  = r_det[k-1];
            assign quot_in = r_quot[k-1];
            assign side_in = r_side[k-1];
        end

        assign t  = REM_W'(det_in) << BIT;
        assign ge = rem_in >= t;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? rem_in - t : rem_in;
                r_det[k]  <= det_in;
                r_quot[k] <= quot_in | (Q_W'(ge) << BIT);
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quot  = r_quot[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

// File: design/segment_crossing_over_under.sv
// ----------------------------------------------------------------------------
// segment_crossing_over_under
// xy crossing test of two 3d segments with over/under decision, pipelined
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_a_*, i_b_* start/end x y z
//  result    out        o_valid / i_ready    o_crossed, o_which_on_top,
//                                            o_signed_position
//  config    in         i_cfg_we             i_cfg_data (tolerance)
//
// one item per cycle while no result is held; 7 arithmetic stages, 31 divider
// stages of one quotient bit each, one output register
// the divider chain sets the depth; the 34-bit split products set stage timing
// all stages move together; a held result stalls the whole pipe, o_ready low
// synchronous active-low reset clears the valid bits and sets tolerance 1074
// ----------------------------------------------------------------------------
module segment_crossing_over_under (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_a_start_x,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_a_start_y,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_a_start_z,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_a_end_x,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_a_end_y,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_a_end_z,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_b_start_x,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_b_start_y,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_b_start_z,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_b_end_x,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_b_end_y,
    input  logic signed [scou_pkg::COORD_BITS-1:0] i_b_end_z,
    input  logic                                   i_cfg_we,
    input  logic [scou_pkg::TOL_W-1:0]             i_cfg_data,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_crossed,
    output logic signed [1:0]                      o_which_on_top,
    output logic signed [scou_pkg::POS_W-1:0]      o_signed_position
);
    import scou_pkg::*;

    logic              en;
    logic [TOL_W-1:0]  r_tol;
    logic [6:0]        r_v;

    // stage 1: differences
    logic signed [DIFF_W-1:0] r_x00, r_x10, r_x01, r_x11, r_b0, r_b1;
    logic signed [DIFF_W-1:0] r_dza1, r_dzb1;
    logic signed [COORD_BITS-1:0] r_za1, r_zb1;
    // stage 2: products
    logic signed [PROD_W-1:0] r_pa, r_pb, r_pc, r_pd, r_pe, r_pf;
    logic signed [DIFF_W-1:0] r_dza2, r_dzb2;
    logic signed [COORD_BITS-1:0] r_za2, r_zb2;
    // stage 3: determinant and numerators
    logic signed [DET_W-1:0] r_det3, r_n03, r_n13;
    logic signed [DIFF_W-1:0] r_dza3, r_dzb3;
    logic signed [COORD_BITS-1:0] r_za3, r_zb3;
    // stage 4: sign fold
    logic [DET_W-1:0]        r_dm4;
    logic signed [NUM_W-1:0] r_n04, r_n14;
    logic                    r_dneg4, r_detz4;
    logic signed [DIFF_W-1:0] r_dza4, r_dzb4;
    logic signed [COORD_BITS-1:0] r_za4, r_zb4;
    // stage 5: split partial products
    logic [TOL_W+SPLIT-1:0]             r_edl;
    logic [TOL_W+DET_W-SPLIT-1:0]       r_edh;
    logic [HI_W+SPLIT-1:0]              r_hdl;
    logic [HI_W+DET_W-SPLIT-1:0]        r_hdh;
    logic signed [COORD_BITS+SPLIT:0]   r_zadl, r_zbdl;
    logic signed [COORD_BITS+DET_W-SPLIT:0] r_zadh, r_zbdh;
    logic signed [DIFF_W+SPLIT:0]       r_n0l, r_n1l;
    logic signed [DIFF_W+NUM_W-SPLIT-1:0] r_n0h, r_n1h;
    logic [DET_W-1:0]        r_dm5;
    logic signed [NUM_W-1:0] r_n05, r_n15;
    logic                    r_dneg5, r_detz5;
    // stage 6: full products
    logic [EPSD_W-1:0]       r_ed;
    logic [HID_W-1:0]        r_hd;
    logic signed [HGT_W-1:0] r_lhs, r_rhs;
    logic [DET_W-1:0]        r_dm6;
    logic signed [NUM_W-1:0] r_n06, r_n16;
    logic                    r_dneg6, r_detz6;
    // stage 7: window and height decisions, into the divider
    logic [REM_W-1:0]        r_rem7;
    logic [DET_W-1:0]        r_dm7;
    t_side                   r_side7;

    // divider and output
    logic                    dv_valid;
    logic [Q_W-1:0]          dv_quot;
    t_side                   dv_side;
    logic                    r_ovalid;
    logic                    r_ocross;
    logic signed [1:0]       r_otop;
    logic signed [POS_W-1:0] r_opos;

    // whole pipe advances unless a finished result is held
    assign en      = !r_ovalid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_v      <= {r_v[5:0], i_valid};
            r_ovalid <= dv_valid;
        end
    end

    // folded sign and the split slices used by the multipliers
    logic signed [NUM_W-1:0]  detx, n0x, n1x, dmx;
    logic signed [SPLIT:0]    dl_s, n0l_s, n1l_s;
    logic signed [DET_W-SPLIT:0] dh_s;
    logic signed [NUM_W-SPLIT-1:0] n0h_s, n1h_s;
    logic [HI_W-1:0]          hi;
    logic [SPLIT-1:0]         dl;
    logic [DET_W-SPLIT-1:0]   dh;
    logic signed [WIN_W-1:0]  s0, s1, edw, hdw;
    logic                     w0, w1, crossed7, top7;

    always_comb begin
        detx  = NUM_W'(r_det3);
        n0x   = NUM_W'(r_n03);
        n1x   = NUM_W'(r_n13);
        dmx   = r_det3[DET_W-1] ? -detx : detx;
        dl    = r_dm4[SPLIT-1:0];
        dh    = r_dm4[DET_W-1:SPLIT];
        dl_s  = $signed({1'b0, dl});
        dh_s  = $signed({1'b0, dh});
        n0l_s = $signed({1'b0, r_n04[SPLIT-1:0]});
        n1l_s = $signed({1'b0, r_n14[SPLIT-1:0]});
        n0h_s = r_n04[NUM_W-1:SPLIT];
        n1h_s = r_n14[NUM_W-1:SPLIT];
        hi    = ONE_Q - HI_W'(r_tol);
        // bounds are inclusive: tol*det <= n << frac <= (1-tol)*det
        s0    = WIN_W'(r_n06) <<< PARAM_FRAC_BITS;
        s1    = WIN_W'(r_n16) <<< PARAM_FRAC_BITS;
        edw   = $signed(WIN_W'(r_ed));
        hdw   = $signed(WIN_W'(r_hd));
        w0    = (s0 >= edw) && (s0 <= hdw);
        w1    = (s1 >= edw) && (s1 <= hdw);
        crossed7 = !r_detz6 && w0 && w1;
        // equal heights count as b on top
        top7  = r_rhs < r_lhs;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r_x00  <= {i_a_end_x[COORD_BITS-1], i_a_end_x} - {i_a_start_x[COORD_BITS-1], i_a_start_x};
            r_x10  <= {i_a_end_y[COORD_BITS-1], i_a_end_y} - {i_a_start_y[COORD_BITS-1], i_a_start_y};
            r_x01  <= {i_b_start_x[COORD_BITS-1], i_b_start_x} - {i_b_end_x[COORD_BITS-1], i_b_end_x};
            r_x11  <= {i_b_start_y[COORD_BITS-1], i_b_start_y} - {i_b_end_y[COORD_BITS-1], i_b_end_y};
            r_b0   <= {i_b_start_x[COORD_BITS-1], i_b_start_x} - {i_a_start_x[COORD_BITS-1], i_a_start_x};
            r_b1   <= {i_b_start_y[COORD_BITS-1], i_b_start_y} - {i_a_start_y[COORD_BITS-1], i_a_start_y};
            r_dza1 <= {i_a_end_z[COORD_BITS-1], i_a_end_z} - {i_a_start_z[COORD_BITS-1], i_a_start_z};
            r_dzb1 <= {i_b_end_z[COORD_BITS-1], i_b_end_z} - {i_b_start_z[COORD_BITS-1], i_b_start_z};
            r_za1  <= i_a_start_z;
            r_zb1  <= i_b_start_z;
            // stage 2
            r_pa   <= r_x00 * r_x11;
            r_pb   <= r_x01 * r_x10;
            r_pc   <= r_x11 * r_b0;
            r_pd   <= r_x01 * r_b1;
            r_pe   <= r_x00 * r_b1;
            r_pf   <= r_x10 * r_b0;
            r_dza2 <= r_dza1;
            r_dzb2 <= r_dzb1;
            r_za2  <= r_za1;
            r_zb2  <= r_zb1;
            // stage 3
            r_det3 <= DET_W'(r_pa) - DET_W'(r_pb);
            r_n03  <= DET_W'(r_pc) - DET_W'(r_pd);
            r_n13  <= DET_W'(r_pe) - DET_W'(r_pf);
            r_dza3 <= r_dza2;
            r_dzb3 <= r_dzb2;
            r_za3  <= r_za2;
            r_zb3  <= r_zb2;
            // stage 4: make the determinant positive
            r_dm4   <= dmx[DET_W-1:0];
            r_n04   <= r_det3[DET_W-1] ? -n0x : n0x;
            r_n14   <= r_det3[DET_W-1] ? -n1x : n1x;
            r_dneg4 <= r_det3[DET_W-1];
            r_detz4 <= (r_det3 == '0);
            r_dza4  <= r_dza3;
            r_dzb4  <= r_dzb3;
            r_za4   <= r_za3;
            r_zb4   <= r_zb3;
            // stage 5: determinant split in a low and a high slice
            r_edl   <= r_tol * dl;
            r_edh   <= r_tol * dh;
            r_hdl   <= hi * dl;
            r_hdh   <= hi * dh;
            r_zadl  <= r_za4 * dl_s;
            r_zadh  <= r_za4 * dh_s;
            r_zbdl  <= r_zb4 * dl_s;
            r_zbdh  <= r_zb4 * dh_s;
            r_n0l   <= n0l_s * r_dza4;
            r_n0h   <= n0h_s * r_dza4;
            r_n1l   <= n1l_s * r_dzb4;
            r_n1h   <= n1h_s * r_dzb4;
            r_dm5   <= r_dm4;
            r_n05   <= r_n04;
            r_n15   <= r_n14;
            r_dneg5 <= r_dneg4;
            r_detz5 <= r_detz4;
            // stage 6: recombine, heights scaled by det
            r_ed    <= (EPSD_W'(r_edh) << SPLIT) + EPSD_W'(r_edl);
            r_hd    <= (HID_W'(r_hdh) << SPLIT) + HID_W'(r_hdl);
            r_lhs   <= (HGT_W'(r_zadh) <<< SPLIT) + HGT_W'(r_zadl)
                     + (HGT_W'(r_n0h) <<< SPLIT) + HGT_W'(r_n0l);
            r_rhs   <= (HGT_W'(r_zbdh) <<< SPLIT) + HGT_W'(r_zbdl)
                     + (HGT_W'(r_n1h) <<< SPLIT) + HGT_W'(r_n1l);
            r_dm6   <= r_dm5;
            r_n06   <= r_n05;
            r_n16   <= r_n15;
            r_dneg6 <= r_dneg5;
            r_detz6 <= r_detz5;
            // stage 7: numerator enters the divider only on a crossing
            r_rem7  <= crossed7 ? (REM_W'(r_n06[DET_W-1:0]) << PARAM_FRAC_BITS) : '0;
            r_dm7   <= r_dm6;
            r_side7 <= '{crossed: crossed7, top: top7, negout: top7 != r_dneg6};
            // output register
            r_ocross <= dv_side.crossed;
            r_otop   <= !dv_side.crossed ? TOP_NONE : (dv_side.top ? TOP_A : TOP_B);
            r_opos   <= !dv_side.crossed ? '0
                      : (dv_side.negout ? -POS_W'(dv_quot) : POS_W'(dv_quot));
        end
    end

    scou_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v[6]),
        .i_rem   (r_rem7),
        .i_det   (r_dm7),
        .i_side  (r_side7),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    assign o_valid           = r_ovalid;
    assign o_crossed         = r_ocross;
    assign o_which_on_top    = r_otop;
    assign o_signed_position = r_opos;

endmodule

// File: design/scou_checker.sv
// ----------------------------------------------------------------------------
// scou_checker
// port-level checks of the segment crossing block, bound to the top level
// ----------------------------------------------------------------------------
module scou_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic                                o_crossed,
    input logic signed [1:0]                   o_which_on_top,
    input logic signed [scou_pkg::POS_W-1:0]   o_signed_position
);
    import scou_pkg::*;

    localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(1) << PARAM_FRAC_BITS;

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_signed_position)
                                && $stable(o_which_on_top))
        else $error("held item changed");

    // no crossing reports zeros
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_crossed |-> o_which_on_top == TOP_NONE && o_signed_position == '0)
        else $error("non-crossing item not zero");

    // a crossing names a top segment and stays within one
    a_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_crossed |-> (o_which_on_top == TOP_A || o_which_on_top == TOP_B)
            && o_signed_position <= POS_MAX && o_signed_position >= -POS_MAX)
        else $error("crossing item out of range");

    // a stalled output stalls the input side
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stalled");

    // reset empties the pipe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("item after reset");

endmodule

bind segment_crossing_over_under scou_checker u_scou_checker (.*);

// File: sim/segment_crossing_over_under_tb.sv
// ----------------------------------------------------------------------------
// segment_crossing_over_under_tb
// self-checking bench for the xy segment crossing and over/under block: a
// directed table, then random segment pairs over several tolerance and idling
// phases, each result checked against its table value or an exact wide-integer predictor
// ----------------------------------------------------------------------------
module segment_crossing_over_under_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scou_pkg::*;

    typedef logic signed [255:0]            wide_t;
    typedef logic [11:0][COORD_BITS-1:0]    seg_pair_t;   // a0 xyz, a1 xyz, b0 xyz, b1 xyz

    typedef struct packed {
        logic                    crossed;
        logic signed [1:0]       top;
        logic signed [POS_W-1:0] pos;
    } crossing_t;

    typedef struct packed {
        seg_pair_t  seg;
        logic       typed;      // expected value written in the table
        crossing_t  want;
    } table_row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PIPE_DRAIN     = 45;     // more than the depth of the pipeline
    localparam int ITEMS_PER_PHASE = 350;
    localparam int DIRECTED_ROWS  = 12;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  drv_valid = 1'b0;
    logic                  drv_ready = 1'b0;
    seg_pair_t             drv_seg = '0;
    logic                  drv_typed = 1'b0;
    crossing_t             drv_want = '0;
    logic                  cfg_we = 1'b0;
    logic [TOL_W-1:0]      cfg_data = '0;
    logic                  o_ready, o_valid, o_crossed;
    logic signed [1:0]     o_which_on_top;
    logic signed [POS_W-1:0] o_signed_position;

    logic [TOL_W-1:0]      tol_shadow = TOL_RESET;   // predictor copy of tolerance
    crossing_t             pending_crossings[$];
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    quiet_cycles = 0;
    bit                    failed = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    segment_crossing_over_under u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(drv_valid), .o_ready(o_ready),
        .i_a_start_x(drv_seg[0]), .i_a_start_y(drv_seg[1]), .i_a_start_z(drv_seg[2]),
        .i_a_end_x(drv_seg[3]),   .i_a_end_y(drv_seg[4]),   .i_a_end_z(drv_seg[5]),
        .i_b_start_x(drv_seg[6]), .i_b_start_y(drv_seg[7]), .i_b_start_z(drv_seg[8]),
        .i_b_end_x(drv_seg[9]),   .i_b_end_y(drv_seg[10]),  .i_b_end_z(drv_seg[11]),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_valid(o_valid), .i_ready(drv_ready),
        .o_crossed(o_crossed), .o_which_on_top(o_which_on_top),
        .o_signed_position(o_signed_position)
    );

    // exact crossing solve in 256-bit signed arithmetic
    function automatic crossing_t predict_crossing(seg_pair_t s, logic [TOL_W-1:0] tol);
        wide_t v[12];
        wide_t x00, x10, x01, x11, b0, b1, det, n0, n1, eps, hi, lhs, rhs, q;
        logic dneg, top;
        crossing_t r;
        r = '0;
        for (int i = 0; i < 12; i++) v[i] = $signed(s[i]);
        x00 = v[3] - v[0];
        x10 = v[4] - v[1];
        x01 = v[6] - v[9];
        x11 = v[7] - v[10];
        b0  = v[6] - v[0];
        b1  = v[7] - v[1];
        det = x00 * x11 - x01 * x10;
        if (det == 0) return r;                  // parallel projections
        n0 = x11 * b0 - x01 * b1;
        n1 = x00 * b1 - x10 * b0;
        dneg = det < 0;
        if (dneg) begin
            det = -det;
            n0 = -n0;
            n1 = -n1;
        end
        eps = wide_t'({226'b0, tol});
        hi  = (wide_t'(1) <<< PARAM_FRAC_BITS) - eps;
        // inclusive window on both parameters
        if ((n0 <<< PARAM_FRAC_BITS) < eps * det || (n0 <<< PARAM_FRAC_BITS) > hi * det ||
            (n1 <<< PARAM_FRAC_BITS) < eps * det || (n1 <<< PARAM_FRAC_BITS) > hi * det)
            return r;
        // heights compared on the exact rationals, scaled by det
        lhs = v[2] * det + n0 * (v[5] - v[2]);
        rhs = v[8] * det + n1 * (v[11] - v[8]);
        top = rhs < lhs;                         // ties go to b
        q = (n0 <<< PARAM_FRAC_BITS) / det;
        r.crossed = 1'b1;
        r.top = top ? TOP_A : TOP_B;
        r.pos = (top != dneg) ? -q[POS_W-1:0] : q[POS_W-1:0];
        return r;
    endfunction

    // signed value of the given bit width
    function automatic logic [31:0] rnd_bits(int bits);
        return $unsigned($signed($urandom) >>> (32 - bits));
    endfunction

    // mostly pairs inside one box so crossings are common, plus parallel and
    // full-range noise
    function automatic seg_pair_t random_pair();
        seg_pair_t s;
        int mode, bits;
        mode = $urandom_range(99);
        bits = $urandom_range(2, 32);
        for (int i = 0; i < 12; i++) s[i] = (mode < 20) ? $urandom : rnd_bits(bits);
        if (mode >= 90) begin
            // b is a shifted copy of a in xy
            s[6]  = s[0] + s[1][3:0];
            s[7]  = s[1] + s[0][3:0];
            s[9]  = s[3] + s[1][3:0];
            s[10] = s[4] + s[0][3:0];
        end
        return s;
    endfunction

    function automatic seg_pair_t pair_of(int ax0, int ay0, int az0, int ax1, int ay1,
                                          int az1, int bx0, int by0, int bz0, int bx1,
                                          int by1, int bz1);
        return {bz1, by1, bx1, bz0, by0, bx0, az1, ay1, ax1, az0, ay0, ax0};
    endfunction

    // input side monitor: predictor sees exactly the accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_we) tol_shadow <= cfg_data;
        if (i_rst_n && drv_valid && o_ready)
            pending_crossings.insert(pending_crossings.size(),
                                     drv_typed ? drv_want
                                               : predict_crossing(drv_seg, tol_shadow));
    end

    // result side: random backpressure and in-order compare
    always @(posedge i_clk) begin
        crossing_t exp_r;
        drv_ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && o_valid && drv_ready) begin
            if (pending_crossings.size() == 0) begin
                $error("result item with nothing expected");
                failed = 1'b1;
            end else begin
                exp_r = pending_crossings.pop_front();
                if (o_crossed !== exp_r.crossed) begin
                    $error("crossed: expected %0d got %0d", exp_r.crossed, o_crossed);
                    failed = 1'b1;
                end
                if (o_which_on_top !== exp_r.top) begin
                    $error("which_on_top: expected %0d got %0d", exp_r.top, o_which_on_top);
                    failed = 1'b1;
                end
                if (o_signed_position !== exp_r.pos) begin
                    $error("signed_position: expected %0d got %0d",
                           exp_r.pos, o_signed_position);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((drv_valid && o_ready) || (o_valid && drv_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one item: optional random gap, then hold until accepted
    task automatic send_pair(seg_pair_t s, logic typed, crossing_t want);
        while ($urandom_range(99) < idle_pct) begin
            drv_valid <= 1'b0;
            @(posedge i_clk);
        end
        drv_seg   <= s;
        drv_typed <= typed;
        drv_want  <= want;
        drv_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // sender holds off until every result is back and the pipe is empty
    task automatic drain_pipe();
        drv_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_crossings.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        table_row_t directed[DIRECTED_ROWS];
        logic [TOL_W-1:0] tol_plan[5];
        int idle_plan[5], stall_plan[5];
        int half;
        half = 1 << (PARAM_FRAC_BITS - 1);

        // typed rows: parallel, crossing at one half, equal heights, endpoint touch
        directed[0]  = '{pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0};
        directed[1]  = '{{12{32'h7fffffff}}, 1'b1, '0};
        directed[2]  = '{{12{32'h80000000}}, 1'b1, '0};
        directed[3]  = '{pair_of(-1, 0, 1, 1, 0, 1, 0, -1, 0, 0, 1, 0),
                         1'b1, '{1'b1, TOP_A, half}};
        directed[4]  = '{pair_of(-1, 0, 0, 1, 0, 0, 0, -1, 0, 0, 1, 0),
                         1'b1, '{1'b1, TOP_B, -half}};
        directed[5]  = '{pair_of(0, 0, 5, 2, 0, 5, 0, -1, 9, 0, 1, 9),
                         1'b1, '0};
        directed[6]  = '{pair_of(-1, 0, 0, 1, 0, 0, 5, -1, 0, 5, 1, 0),
                         1'b1, '0};
        // predictor rows: extremes of every field, mixed signs, b on top
        directed[7]  = '{pair_of(32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                 32'h7fffffff, 32'h80000000, 32'h80000000),
                         1'b0, '0};
        directed[8]  = '{pair_of(32'h7fffffff, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                 32'h80000000, 32'h80000000, 32'h7fffffff,
                                 32'h7fffffff, 32'h7fffffff, 32'h80000000),
                         1'b0, '0};
        directed[9]  = '{pair_of(-3, 1, -7, 5, 2, 4, 1, -6, 8, 2, 9, 8), 1'b0, '0};
        directed[10] = '{pair_of(0, 0, 0, 3, 1, 0, 1, 3, 4, 2, -2, -4), 1'b0, '0};
        directed[11] = '{pair_of(10, -10, 0, -10, 10, 0, -10, -10, 1, 10, 10, 1),
                         1'b0, '0};

        // tolerance, idling per phase: zero, exactly one half, field max, random, reset
        tol_plan   = '{TOL_W'(0), TOL_W'(half), {TOL_W{1'b1}}, TOL_W'(0), TOL_RESET};
        idle_plan  = '{0, 64, 0, 29, 0};
        stall_plan = '{0, 0, 64, 29, 0};
        tol_plan[3] = TOL_W'($urandom_range(0, half));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset tolerance
        foreach (directed[i]) send_pair(directed[i].seg, directed[i].typed, directed[i].want);
        drain_pipe();
        // a half tolerance still admits a crossing exactly at one half
        write_tolerance(TOL_W'(half));
        send_pair(pair_of(-1, 0, 1, 1, 0, 1, 0, -1, 0, 0, 1, 0), 1'b1,
                  '{1'b1, TOP_A, half});
        drain_pipe();

        for (int p = 0; p < 5; p++) begin
            write_tolerance(tol_plan[p]);
            idle_pct  = idle_plan[p];
            stall_pct = stall_plan[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_pair(random_pair(), 1'b0, '0);
            drain_pipe();
        end

        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/scou_pkg.sv
design/scou_divider.sv
design/segment_crossing_over_under.sv
design/scou_checker.sv
sim/segment_crossing_over_under_tb.sv
